// ===== design/vca_pkg.sv =====
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types, constants and helpers of the voice channel allocator.
// ----------------------------------------------------------------------------
package vca_pkg;

	localparam int MAX_SLOTS = 18;
	localparam int AGE_BITS  = 16;
	localparam int NOTE_W    = 7;
	localparam int OP_W      = 2;
	localparam int SLOT_W    = 5;
	localparam int CFG_W     = 5;
	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [NOTE_W-1:0]   note;
		logic [AGE_BITS-1:0] age;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} ram_req_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_SLOTS) begin
			r = CNT_W'(MAX_SLOTS);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== design/vca_req_if.sv =====
// ----------------------------------------------------------------------------
// vca_req_if
// Request channel: operation and note, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vca_req_if import vca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [NOTE_W-1:0] note;

	modport source (output valid, output operation, output note, input ready);
	modport sink   (input valid, input operation, input note, output ready);
endinterface

// ===== design/vca_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vca_rsp_if
// Response channel: slot and found flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vca_rsp_if import vca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot;
	logic              found;

	modport source (output valid, output slot, output found, input ready);
	modport sink   (input valid, input slot, input found, output ready);
endinterface

// ===== design/vca_slot_ram.sv =====
// ----------------------------------------------------------------------------
// vca_slot_ram
// Slot table memory: note and age per slot, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module vca_slot_ram import vca_pkg::*; (
	input  logic     clk,
	input  ram_req_t req,
	output entry_t   rd_data
);

	entry_t mem_q [MAX_SLOTS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/vca_ctrl.sv =====
// ----------------------------------------------------------------------------
// vca_ctrl
// Allocation sequencer: scans the slot table one entry per cycle, ages and
// writes back on note-on, matches on note-off, then places or frees a slot.
// ----------------------------------------------------------------------------
module vca_ctrl import vca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	vca_req_if.sink          req,
	vca_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output ram_req_t         ram_req,
	input  entry_t           ram_rd_data
);

	state_t state_q, state_d;
	op_t    op_q;

	logic [NOTE_W-1:0]    note_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     ptr_eff;
	logic [MAX_SLOTS-1:0] busy_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic                any_vld_q, ge_vld_q, hit_vld_q;
	logic [IDX_W-1:0]    any_idx_q, ge_idx_q, hit_idx_q, best_idx_q;
	logic [AGE_BITS-1:0] best_age_q;

	logic [IDX_W-1:0]  res_slot_q;
	logic              res_found_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_found_q;

	logic                in_acc;
	logic                issue;
	logic                scan_last;
	logic                load_ok;
	logic                out_load;
	logic [AGE_BITS-1:0] aged;
	logic [IDX_W-1:0]    fin_slot;
	logic                fin_placed;
	logic [CNT_W-1:0]    fin_nxt;
	logic [IDX_W-1:0]    fin_next_ptr;

	assign in_acc    = req.valid && req.ready;
	assign load_ok   = !out_valid_q || rsp.ready;
	assign scan_last = vld_s1 && (CNT_W'(idx_s1) == count_q - CNT_W'(1));
	assign ptr_eff   = (CNT_W'(ptr_q) >= count_q) ? '0 : ptr_q;
	assign aged      = (ram_rd_data.age == '1) ? ram_rd_data.age
		: ram_rd_data.age + AGE_BITS'(1);

	// round robin: first free at or after pointer, else first free overall, else oldest
	assign fin_placed   = ge_vld_q || any_vld_q;
	assign fin_slot     = ge_vld_q ? ge_idx_q : (any_vld_q ? any_idx_q : best_idx_q);
	assign fin_nxt      = CNT_W'(fin_slot) + CNT_W'(1);
	assign fin_next_ptr = (fin_nxt >= count_q) ? '0 : fin_nxt[IDX_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req.operation == OP_NOTE_ON || req.operation == OP_NOTE_OFF) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req.ready        = (state_q == ST_IDLE);
		issue            = 1'b0;
		out_load         = 1'b0;
		ram_req.rd_en    = 1'b0;
		ram_req.rd_addr  = rd_idx_q[IDX_W-1:0];
		ram_req.wr_en    = 1'b0;
		ram_req.wr_addr  = idx_s1;
		ram_req.wr_data  = '{note: ram_rd_data.note, age: aged};
		case (state_q)
			ST_SCAN: begin
				issue         = (rd_idx_q < count_q);
				ram_req.rd_en = issue;
				// age write-back trails the read by one entry
				ram_req.wr_en = vld_s1 && (op_q == OP_NOTE_ON);
			end
			ST_FINISH: begin
				ram_req.wr_en   = (op_q == OP_NOTE_ON);
				ram_req.wr_addr = fin_slot;
				ram_req.wr_data = '{note: note_q, age: '0};
			end
			ST_DONE: begin
				out_load = load_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= clamp_count(CFG_W'(MAX_SLOTS));
			ptr_q       <= '0;
			busy_q      <= '0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			any_vld_q   <= 1'b0;
			ge_vld_q    <= 1'b0;
			hit_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_q == ST_IDLE) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end

			if (in_acc) begin
				any_vld_q <= 1'b0;
				ge_vld_q  <= 1'b0;
				hit_vld_q <= 1'b0;
			end else if (state_q == ST_SCAN && vld_s1) begin
				if (op_q == OP_NOTE_ON && !busy_q[idx_s1]) begin
					any_vld_q <= 1'b1;
					if (idx_s1 >= ptr_eff) begin
						ge_vld_q <= 1'b1;
					end
				end
				if (op_q == OP_NOTE_OFF && busy_q[idx_s1] && ram_rd_data.note == note_q) begin
					hit_vld_q <= 1'b1;
				end
			end

			if (cfg_we) begin
				count_q <= clamp_count(cfg_wdata);
				busy_q  <= '0;
				ptr_q   <= '0;
			end else begin
				if (in_acc && req.operation == OP_CLEAR) begin
					busy_q <= '0;
				end
				if (state_q == ST_FINISH) begin
					if (op_q == OP_NOTE_ON) begin
						busy_q[fin_slot] <= 1'b1;
						if (fin_placed) begin
							ptr_q <= fin_next_ptr;
						end
					end else if (op_q == OP_NOTE_OFF && hit_vld_q) begin
						busy_q[hit_idx_q] <= 1'b0;
					end
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q        <= op_t'(req.operation);
			note_q      <= req.note;
			res_slot_q  <= '0;
			res_found_q <= 1'b0;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == ST_SCAN && vld_s1) begin
			if (idx_s1 == '0 || aged > best_age_q) begin
				best_idx_q <= idx_s1;
				best_age_q <= aged;
			end
			if (!busy_q[idx_s1] && !any_vld_q) begin
				any_idx_q <= idx_s1;
			end
			if (!busy_q[idx_s1] && !ge_vld_q && idx_s1 >= ptr_eff) begin
				ge_idx_q <= idx_s1;
			end
			if (busy_q[idx_s1] && ram_rd_data.note == note_q && !hit_vld_q) begin
				hit_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_FINISH) begin
			if (op_q == OP_NOTE_ON) begin
				res_slot_q  <= fin_slot;
				res_found_q <= 1'b1;
			end else if (hit_vld_q) begin
				res_slot_q  <= hit_idx_q;
				res_found_q <= 1'b1;
			end
		end
		if (out_load) begin
			out_slot_q  <= SLOT_W'(res_slot_q);
			out_found_q <= res_found_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.slot  = out_slot_q;
	assign rsp.found = out_found_q;

`ifndef SYNTHESIS
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(ptr_q) < count_q)
		else $error("search pointer beyond channel count");

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
		else $error("read and write hit the same slot entry");

	a_place_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && op_q == OP_NOTE_ON) |-> (CNT_W'(fin_slot) < count_q))
		else $error("note placed outside active slots");

	a_place_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && op_q == OP_NOTE_ON) |=> busy_q[$past(fin_slot)])
		else $error("placed slot not marked busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside completion");
`endif

endmodule

// ===== design/voice_channel_allocator_top.sv =====
// ----------------------------------------------------------------------------
// voice_channel_allocator_top
// Round-robin voice allocator with oldest-voice steal over a slot table.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A note-on or note-off scans the active
// slots through the slot memory one entry per cycle (read, then on note-on
// the age write-back in the cycle after), then finishes before the next item
// can be accepted; clear and the unused code skip the scan. The finished
// result sits in an output register, so a new item is taken while it waits.
// Writing the channel count frees all slots and resets the search pointer in
// the same cycle; no clearing pass is needed after reset.
module voice_channel_allocator_top import vca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	vca_req_if.sink          req,
	vca_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	ram_req_t ram_req;
	entry_t   ram_rd_data;

	vca_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data)
	);

	vca_slot_ram u_slot_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd_data)
	);

endmodule
